// File: hdl/dtc_pkg.sv
// Shared types and constants for the cascadable dual timer.
// No dependencies; imported by every module of the block.
package dtc_pkg;

  localparam int unsigned DATA_W = 32;

  // Config word bit positions
  localparam int unsigned BIT_EN      = 0;
  localparam int unsigned BIT_RST     = 1;
  localparam int unsigned BIT_IRQEN   = 2;
  localparam int unsigned BIT_IEM     = 3;
  localparam int unsigned BIT_CLR     = 4;
  localparam int unsigned BIT_ONESHOT = 5;
  localparam int unsigned BIT_PRE_EN  = 6;
  localparam int unsigned BIT_REF_EN  = 7;
  localparam int unsigned PRE_LSB     = 8;
  localparam int unsigned PRE_MSB     = 15;
  localparam int unsigned BIT_MODE64  = 31;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_EVENT = 2'd3
  } action_e;

  // Register group, reg_index[3:1]
  typedef enum logic [2:0] {
    GRP_CFG   = 3'd0,
    GRP_CNT   = 3'd1,
    GRP_CMP   = 3'd2,
    GRP_START = 3'd3,
    GRP_RESET = 3'd4,
    GRP_BAD5  = 3'd5,
    GRP_BAD6  = 3'd6,
    GRP_BAD7  = 3'd7
  } reg_grp_e;

  typedef struct packed {
    logic [DATA_W-1:0] presc;
    logic              step;
  } pre_upd_t;

  typedef struct packed {
    logic [DATA_W-1:0] cnt0;
    logic [DATA_W-1:0] cnt1;
    logic              en_clr0;
    logic              en_clr1;
    logic              irq0;
    logic              irq1;
  } cnt_upd_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              bad;
    logic              irq_lo;
    logic              irq_hi;
  } result_t;

endpackage

// File: hdl/dtc_presc.sv
// Edge gating and 2^p prescaler for one timer.
// Depends on dtc_pkg.
module dtc_presc import dtc_pkg::*; (
  input  logic              tick_i,
  input  logic              ref_edge_i,
  input  logic [DATA_W-1:0] cfg_i,
  input  logic [DATA_W-1:0] presc_i,
  output pre_upd_t          upd_o
);

  logic              active;
  logic [4:0]        p_exp;
  logic [DATA_W-1:0] limit;

  always_comb begin
    active = tick_i && cfg_i[BIT_EN] && (!cfg_i[BIT_REF_EN] || ref_edge_i);
    p_exp  = 5'd0;
    if (cfg_i[BIT_PRE_EN]) begin
      // exponent clamps to 31
      p_exp = (cfg_i[PRE_MSB:PRE_LSB+5] != 3'd0) ? 5'd31 : cfg_i[PRE_LSB+4:PRE_LSB];
    end
    limit = 32'h7FFF_FFFF >> (5'd31 - p_exp);

    upd_o.presc = presc_i;
    upd_o.step  = 1'b0;
    if (active) begin
      if (presc_i < limit) begin
        upd_o.presc = presc_i + 32'd1;
      end else begin
        upd_o.presc = '0;
        upd_o.step  = 1'b1;
      end
    end
  end

endmodule

// File: hdl/dtc_count.sv
// Count increment, compare match and match action for both timers,
// including the 64-bit cascaded form. Depends on dtc_pkg.
module dtc_count import dtc_pkg::*; (
  input  logic              wide_i,
  input  logic              step0_i,
  input  logic              step1_i,
  input  logic [DATA_W-1:0] cfg0_i,
  input  logic [DATA_W-1:0] cfg1_i,
  input  logic [DATA_W-1:0] cnt0_i,
  input  logic [DATA_W-1:0] cnt1_i,
  input  logic [DATA_W-1:0] cmp0_i,
  input  logic [DATA_W-1:0] cmp1_i,
  output cnt_upd_t          upd_o
);

  logic [2*DATA_W-1:0] sum64;
  logic [DATA_W-1:0]   sum0;
  logic [DATA_W-1:0]   sum1;
  logic                hit0;
  logic                hit1;

  always_comb begin
    sum64 = {cnt1_i, cnt0_i} + 64'd1;
    sum0  = cnt0_i + 32'd1;
    sum1  = cnt1_i + 32'd1;

    upd_o.cnt0    = cnt0_i;
    upd_o.cnt1    = cnt1_i;
    upd_o.en_clr0 = 1'b0;
    upd_o.en_clr1 = 1'b0;
    upd_o.irq0    = 1'b0;
    upd_o.irq1    = 1'b0;
    hit0          = 1'b0;
    hit1          = 1'b0;

    // timer 0, alone or as the low half of the 64-bit timer
    if (step0_i) begin
      if (wide_i) begin
        upd_o.cnt0 = sum64[DATA_W-1:0];
        upd_o.cnt1 = sum64[2*DATA_W-1:DATA_W];
        hit0       = (sum64 == {cmp1_i, cmp0_i});
      end else begin
        upd_o.cnt0 = sum0;
        hit0       = (sum0 == cmp0_i);
      end
      if (hit0) begin
        if (cfg0_i[BIT_ONESHOT]) begin
          upd_o.en_clr0 = 1'b1;
          upd_o.cnt0    = cmp0_i;
          if (wide_i) begin
            upd_o.en_clr1 = 1'b1;
            upd_o.cnt1    = cmp1_i;
          end
        end else if (cfg0_i[BIT_CLR]) begin
          upd_o.cnt0 = '0;
          if (wide_i) begin
            upd_o.cnt1 = '0;
          end
        end
        upd_o.irq0 = cfg0_i[BIT_IRQEN];
      end
    end

    // timer 1 counts only when not cascaded
    if (step1_i && !wide_i) begin
      upd_o.cnt1 = sum1;
      hit1       = (sum1 == cmp1_i);
      if (hit1) begin
        if (cfg1_i[BIT_ONESHOT]) begin
          upd_o.en_clr1 = 1'b1;
          upd_o.cnt1    = cmp1_i;
        end else if (cfg1_i[BIT_CLR]) begin
          upd_o.cnt1 = '0;
        end
        upd_o.irq1 = cfg1_i[BIT_IRQEN];
      end
    end
  end

endmodule

// File: hdl/dual_timer_cascadable_64.sv
// Dual 32-bit timer, cascadable into one 64-bit timer; top level.
// Depends on dtc_pkg, dtc_presc and dtc_count.
//
// Each request is one action: a tick, a bus write, a bus read or an event
// pulse, and every request yields exactly one result (read data, bad address
// flag, and one interrupt pulse per timer). A request is taken while
// in_ready_o is high and its result is registered; throughput is then one
// request per clock. The longest path is the 64-bit increment and compare
// in the counter unit feeding the count registers. A two-entry output stage
// (result register plus skid register) takes one more request while the
// result side stalls; in_ready_o drops only when both entries are occupied.
// Setting bit 31 of timer 0's config joins the timers: timer 0's config then
// governs the pair and timer 1 holds the upper count and compare words.
module dual_timer_cascadable_64 import dtc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [3:0]        reg_index_i,
  input  logic [DATA_W-1:0] write_data_i,
  input  logic              ref_edge_i,
  input  logic [1:0]        event_lines_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] read_data_o,
  output logic              bad_address_o,
  output logic              irq_low_o,
  output logic              irq_high_o
);

  // timer state
  logic [DATA_W-1:0] cfg_q   [2];
  logic [DATA_W-1:0] cfg_d   [2];
  logic [DATA_W-1:0] cnt_q   [2];
  logic [DATA_W-1:0] cnt_d   [2];
  logic [DATA_W-1:0] cmp_q   [2];
  logic [DATA_W-1:0] cmp_d   [2];
  logic [DATA_W-1:0] presc_q [2];
  logic [DATA_W-1:0] presc_d [2];

  // output stage
  result_t res_q;
  result_t skid_q;
  logic    res_valid_q;
  logic    skid_valid_q;
  result_t res_new;

  logic        accept;
  logic        out_fire;
  logic        wide;
  logic        is_tick;
  logic        sel;
  action_e     act;
  reg_grp_e    grp;
  pre_upd_t    pre0;
  pre_upd_t    pre1;
  cnt_upd_t    cupd;
  logic [DATA_W-1:0] wcfg;

  assign accept     = in_valid_i && in_ready_o;
  assign out_fire   = res_valid_q && out_ready_i;
  assign in_ready_o = !skid_valid_q;

  assign act     = action_e'(action_i);
  assign grp     = reg_grp_e'(reg_index_i[3:1]);
  assign sel     = reg_index_i[0];
  assign wide    = cfg_q[0][BIT_MODE64];
  assign is_tick = accept && (act == ACT_TICK);

  // prescalers; timer 1's is frozen while cascaded
  dtc_presc u_presc0 (
    .tick_i     (is_tick),
    .ref_edge_i (ref_edge_i),
    .cfg_i      (cfg_q[0]),
    .presc_i    (presc_q[0]),
    .upd_o      (pre0)
  );

  dtc_presc u_presc1 (
    .tick_i     (is_tick && !wide),
    .ref_edge_i (ref_edge_i),
    .cfg_i      (cfg_q[1]),
    .presc_i    (presc_q[1]),
    .upd_o      (pre1)
  );

  dtc_count u_count (
    .wide_i  (wide),
    .step0_i (pre0.step),
    .step1_i (pre1.step),
    .cfg0_i  (cfg_q[0]),
    .cfg1_i  (cfg_q[1]),
    .cnt0_i  (cnt_q[0]),
    .cnt1_i  (cnt_q[1]),
    .cmp0_i  (cmp_q[0]),
    .cmp1_i  (cmp_q[1]),
    .upd_o   (cupd)
  );

  // request decode and state update
  always_comb begin
    cfg_d   = cfg_q;
    cnt_d   = cnt_q;
    cmp_d   = cmp_q;
    presc_d = presc_q;
    res_new = '0;
    wcfg    = write_data_i;

    if (accept) begin
      case (act)
        ACT_TICK: begin
          presc_d[0] = pre0.presc;
          presc_d[1] = pre1.presc;
          cnt_d[0]   = cupd.cnt0;
          cnt_d[1]   = cupd.cnt1;
          if (cupd.en_clr0) begin
            cfg_d[0][BIT_EN] = 1'b0;
          end
          if (cupd.en_clr1) begin
            cfg_d[1][BIT_EN] = 1'b0;
          end
          res_new.irq_lo = cupd.irq0;
          res_new.irq_hi = cupd.irq1;
        end
        ACT_WRITE: begin
          case (grp)
            GRP_CFG: begin
              // RST in the written word acts at once and never sticks
              if (wcfg[BIT_RST]) begin
                cnt_d[sel]   = '0;
                presc_d[sel] = '0;
                if (!sel && wcfg[BIT_MODE64]) begin
                  cnt_d[1] = '0;
                end
              end
              wcfg[BIT_RST] = 1'b0;
              cfg_d[sel]    = wcfg;
            end
            GRP_CNT:   cnt_d[sel] = write_data_i;
            GRP_CMP:   cmp_d[sel] = write_data_i;
            GRP_START: cfg_d[sel][BIT_EN] = 1'b1;
            GRP_RESET: begin
              cnt_d[sel]   = '0;
              presc_d[sel] = '0;
              if (!sel && wide) begin
                cnt_d[1] = '0;
              end
              cfg_d[sel][BIT_RST] = 1'b0;
            end
            default:   res_new.bad = 1'b1;
          endcase
        end
        ACT_READ: begin
          case (grp)
            GRP_CFG: res_new.rdata = cfg_q[sel];
            GRP_CNT: res_new.rdata = cnt_q[sel];
            GRP_CMP: res_new.rdata = cmp_q[sel];
            default: res_new.bad   = 1'b1;
          endcase
        end
        ACT_EVENT: begin
          // an event starts only timers armed for it
          if (event_lines_i[0] && cfg_q[0][BIT_IEM]) begin
            cfg_d[0][BIT_EN] = 1'b1;
          end
          if (event_lines_i[1] && cfg_q[1][BIT_IEM]) begin
            cfg_d[1][BIT_EN] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '{default: '0};
      cnt_q   <= '{default: '0};
      cmp_q   <= '{default: '0};
      presc_q <= '{default: '0};
    end else begin
      cfg_q   <= cfg_d;
      cnt_q   <= cnt_d;
      cmp_q   <= cmp_d;
      presc_q <= presc_d;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        // no request taken while the skid entry is full
        if (out_fire) begin
          res_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (!res_valid_q || out_fire) begin
          res_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        res_q <= skid_q;
      end
    end else if (accept) begin
      if (!res_valid_q || out_fire) begin
        res_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign out_valid_o   = res_valid_q;
  assign read_data_o   = res_q.rdata;
  assign bad_address_o = res_q.bad;
  assign irq_low_o     = res_q.irq_lo;
  assign irq_high_o    = res_q.irq_hi;

endmodule
